/* rtl/tbfm_pkg.sv */
// Package for the tile border flood mask block.
// Holds the tile geometry, pixel codes and seed mode codes; no dependencies.
package tbfm_pkg;

    localparam int TILE_SIDE = 8;
    localparam int PIX_W     = 4;
    localparam int ROW_W     = TILE_SIDE * PIX_W;
    localparam int CMD_W     = 2;
    localparam int CNT_W     = $clog2(TILE_SIDE);

    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [TILE_SIDE-1:0] mask_t;
    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [CMD_W-1:0]     cmd_t;

    localparam pix_t WHITE_PIX = 4'hF;
    localparam pix_t BLACK_PIX = 4'h0;
    localparam pix_t RAISE_PIX = 4'h1;

    localparam cmd_t MODE_ALL = 2'd0;
    localparam cmd_t MODE_TL  = 2'd1;
    localparam cmd_t MODE_TR  = 2'd2;

    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(TILE_SIDE - 1);

endpackage

/* rtl/tbfm_if.sv */
// Valid/ready channel interfaces for tile requests and masked tile results.
// Depends on tbfm_pkg for the row and command types.
interface tbfm_req_if;
    logic            valid;
    logic            ready;
    tbfm_pkg::cmd_t  cmd;
    tbfm_pkg::row_t  row_in0;
    tbfm_pkg::row_t  row_in1;
    tbfm_pkg::row_t  row_in2;
    tbfm_pkg::row_t  row_in3;
    tbfm_pkg::row_t  row_in4;
    tbfm_pkg::row_t  row_in5;
    tbfm_pkg::row_t  row_in6;
    tbfm_pkg::row_t  row_in7;

    modport source (
        output valid, cmd, row_in0, row_in1, row_in2, row_in3,
               row_in4, row_in5, row_in6, row_in7,
        input  ready
    );
    modport sink (
        input  valid, cmd, row_in0, row_in1, row_in2, row_in3,
               row_in4, row_in5, row_in6, row_in7,
        output ready
    );
endinterface

interface tbfm_rsp_if;
    logic            valid;
    logic            ready;
    tbfm_pkg::row_t  row_out0;
    tbfm_pkg::row_t  row_out1;
    tbfm_pkg::row_t  row_out2;
    tbfm_pkg::row_t  row_out3;
    tbfm_pkg::row_t  row_out4;
    tbfm_pkg::row_t  row_out5;
    tbfm_pkg::row_t  row_out6;
    tbfm_pkg::row_t  row_out7;

    modport source (
        output valid, row_out0, row_out1, row_out2, row_out3,
               row_out4, row_out5, row_out6, row_out7,
        input  ready
    );
    modport sink (
        input  valid, row_out0, row_out1, row_out2, row_out3,
               row_out4, row_out5, row_out6, row_out7,
        output ready
    );
endinterface

/* rtl/tbfm_dilate.sv */
// Shared row dilation unit: grows the mark of one row by one step inside white.
// Depends on tbfm_pkg for the mask type.
module tbfm_dilate (
    input  tbfm_pkg::mask_t white,
    input  tbfm_pkg::mask_t mark_cur,
    input  tbfm_pkg::mask_t mark_up,
    input  tbfm_pkg::mask_t mark_down,
    input  logic            has_up,
    input  logic            has_down,
    output tbfm_pkg::mask_t mark_new,
    output logic            changed
);

    tbfm_pkg::mask_t grow;

    always_comb
    begin
        grow = mark_cur | (mark_cur << 1) | (mark_cur >> 1);
        if (has_up)
        begin
            grow = grow | mark_up;
        end
        if (has_down)
        begin
            grow = grow | mark_down;
        end
        mark_new = mark_cur | (grow & white);
        changed  = (mark_new != mark_cur);
    end

endmodule

/* rtl/tbfm_remap.sv */
// Output remap of one row: marked pixels become 0 and unmarked zeros become 1.
// Depends on tbfm_pkg for the row, mask and pixel codes.
module tbfm_remap (
    input  tbfm_pkg::row_t  pix_row,
    input  tbfm_pkg::mask_t mark,
    output tbfm_pkg::row_t  out_row
);

    always_comb
    begin
        out_row = pix_row;
        for (int x = 0; x < tbfm_pkg::TILE_SIDE; x++)
        begin
            if (mark[x])
            begin
                out_row[x*tbfm_pkg::PIX_W +: tbfm_pkg::PIX_W] = tbfm_pkg::BLACK_PIX;
            end
            else if (pix_row[x*tbfm_pkg::PIX_W +: tbfm_pkg::PIX_W] == tbfm_pkg::BLACK_PIX)
            begin
                out_row[x*tbfm_pkg::PIX_W +: tbfm_pkg::PIX_W] = tbfm_pkg::RAISE_PIX;
            end
        end
    end

endmodule

/* rtl/tile_border_flood_mask_unit.sv */
// Tile border flood mask, top level: sequencer, tile storage and result port.
// Depends on tbfm_pkg, tbfm_if, tbfm_dilate and tbfm_remap.
//
// A request on tile_req carries a seed mode (cmd) and eight row words of an
// 8x8 tile of 4-bit pixels. White pixels on the chosen edges seed a mark that
// spreads through 4-connected white pixels. The result on tile_rsp gives the
// tile with marked pixels set to 0 and other zero pixels raised to 1.
// One tile is in flight at a time; tile_req.ready is high only while idle.
// After acceptance the tile is swept one row per cycle through a single row
// dilation unit, the rows rotating past it. Sweeps repeat until one
// completes with no new mark, so a tile needs N sweeps, where N is 1 plus
// the number of sweeps that add marks. Each such sweep marks at least one of
// at most 63 unseeded pixels, so N is at most 64; a tile whose marks do not
// spread beyond its seeds ends after its first sweep. The next request can
// be taken in the cycle after the result is taken.
// The result is held on tile_rsp, valid high, until tile_rsp.ready takes it;
// a stalled receiver simply holds the block in that state.
// Reset returns the block to idle and drops any tile in progress.
module tile_border_flood_mask_unit (
    input  logic              clk,
    input  logic              rst_n,
    tbfm_req_if.sink          tile_req,
    tbfm_rsp_if.source        tile_rsp
);

    localparam int S = tbfm_pkg::TILE_SIDE;
    localparam int P = tbfm_pkg::PIX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t                        state_reg, state_next;
    logic [tbfm_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          chg_reg, chg_next;

    tbfm_pkg::row_t                pix_reg   [S];
    tbfm_pkg::row_t                pix_next  [S];
    tbfm_pkg::mask_t               white_reg [S];
    tbfm_pkg::mask_t               white_next[S];
    tbfm_pkg::mask_t               mark_reg  [S];
    tbfm_pkg::mask_t               mark_next [S];

    tbfm_pkg::row_t                in_rows   [S];
    tbfm_pkg::mask_t               in_white  [S];
    tbfm_pkg::mask_t               in_mark   [S];
    tbfm_pkg::row_t                out_rows  [S];

    tbfm_pkg::mask_t               row_mark_new;
    logic                          row_changed;
    logic                          seed_bottom;
    logic                          left_seed;
    logic                          seed_right;
    logic                          accept;

    assign in_rows[0] = tile_req.row_in0;
    assign in_rows[1] = tile_req.row_in1;
    assign in_rows[2] = tile_req.row_in2;
    assign in_rows[3] = tile_req.row_in3;
    assign in_rows[4] = tile_req.row_in4;
    assign in_rows[5] = tile_req.row_in5;
    assign in_rows[6] = tile_req.row_in6;
    assign in_rows[7] = tile_req.row_in7;

    assign tile_req.ready = (state_reg == ST_IDLE);
    assign accept         = tile_req.valid && tile_req.ready;

    assign seed_bottom = (tile_req.cmd != tbfm_pkg::MODE_TL) &&
                         (tile_req.cmd != tbfm_pkg::MODE_TR);
    assign left_seed   = (tile_req.cmd != tbfm_pkg::MODE_TR);
    assign seed_right  = (tile_req.cmd != tbfm_pkg::MODE_TL);

    always_comb
    begin
        for (int y = 0; y < S; y++)
        begin
            for (int x = 0; x < S; x++)
            begin
                in_white[y][x] = (in_rows[y][x*P +: P] == tbfm_pkg::WHITE_PIX);
                in_mark[y][x]  = in_white[y][x] &&
                                 ((y == 0) ||
                                  ((y == S - 1) && seed_bottom) ||
                                  ((x == 0) && left_seed) ||
                                  ((x == S - 1) && seed_right));
            end
        end
    end

    tbfm_dilate u_dilate (
        .white     (white_reg[0]),
        .mark_cur  (mark_reg[0]),
        .mark_up   (mark_reg[S-1]),
        .mark_down (mark_reg[1]),
        .has_up    (cnt_reg != '0),
        .has_down  (cnt_reg != tbfm_pkg::LAST_ROW),
        .mark_new  (row_mark_new),
        .changed   (row_changed)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        chg_next   = chg_reg;
        for (int y = 0; y < S; y++)
        begin
            pix_next[y]   = pix_reg[y];
            white_next[y] = white_reg[y];
            mark_next[y]  = mark_reg[y];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    for (int y = 0; y < S; y++)
                    begin
                        pix_next[y]   = in_rows[y];
                        white_next[y] = in_white[y];
                        mark_next[y]  = in_mark[y];
                    end
                    cnt_next   = '0;
                    chg_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                for (int y = 0; y < S - 1; y++)
                begin
                    pix_next[y]   = pix_reg[y+1];
                    white_next[y] = white_reg[y+1];
                    mark_next[y]  = mark_reg[y+1];
                end
                pix_next[S-1]   = pix_reg[0];
                white_next[S-1] = white_reg[0];
                mark_next[S-1]  = row_mark_new;
                if (cnt_reg == tbfm_pkg::LAST_ROW)
                begin
                    cnt_next = '0;
                    chg_next = 1'b0;
                    if (!(chg_reg || row_changed))
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + tbfm_pkg::CNT_W'(1);
                    chg_next = chg_reg || row_changed;
                end
            end
            ST_OUT:
            begin
                if (tile_rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            chg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            chg_reg   <= chg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int y = 0; y < S; y++)
        begin
            pix_reg[y]   <= pix_next[y];
            white_reg[y] <= white_next[y];
            mark_reg[y]  <= mark_next[y];
        end
    end

    for (genvar g = 0; g < S; g++)
    begin : g_remap
        tbfm_remap u_remap (
            .pix_row (pix_reg[g]),
            .mark    (mark_reg[g]),
            .out_row (out_rows[g])
        );
    end

    assign tile_rsp.valid    = (state_reg == ST_OUT);
    assign tile_rsp.row_out0 = out_rows[0];
    assign tile_rsp.row_out1 = out_rows[1];
    assign tile_rsp.row_out2 = out_rows[2];
    assign tile_rsp.row_out3 = out_rows[3];
    assign tile_rsp.row_out4 = out_rows[4];
    assign tile_rsp.row_out5 = out_rows[5];
    assign tile_rsp.row_out6 = out_rows[6];
    assign tile_rsp.row_out7 = out_rows[7];

endmodule

/* tb/tb_tile_border_flood_mask_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tile_border_flood_mask_unit: a directed table, then random tiles.
// Depends on tbfm_pkg, tbfm_if and the block; a built-in flood predictor checks untyped tiles.
module tb_tile_border_flood_mask_unit;

    localparam int SIDE = tbfm_pkg::TILE_SIDE;
    localparam int PW   = tbfm_pkg::PIX_W;

    typedef logic [SIDE-1:0][tbfm_pkg::ROW_W-1:0] tile_t;

    typedef struct packed {
        tbfm_pkg::cmd_t cmd;
        tile_t          tile;
        logic           typed;
        tile_t          want;
    } dir_row_t;

    localparam tbfm_pkg::cmd_t MODE_SPARE   = 2'd3;
    localparam int             N_RANDOM     = 1030;
    localparam int             HOLD_CYCLES  = 600;
    localparam int             DRAIN_CYCLES = 600;

    logic clk;
    logic rst_n;

    tbfm_req_if tile_req ();
    tbfm_rsp_if tile_rsp ();

    tile_border_flood_mask_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .tile_req (tile_req),
        .tile_rsp (tile_rsp)
    );

    tile_t    masked_q [$];
    dir_row_t dir_tab  [$];
    int       mismatches   = 0;
    int       results_seen = 0;
    int       req_idle_pct;
    int       rsp_idle_pct = 50;
    logic     hold_off;
    logic     pressure_go;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic tile_t flood_mask(tbfm_pkg::cmd_t mode, tile_t tile);
        tbfm_pkg::mask_t white [SIDE];
        tbfm_pkg::mask_t mark  [SIDE];
        tile_t           masked;
        tbfm_pkg::pix_t  pix;
        logic            seed;
        logic            grown;
        masked = '0;
        for (int y = 0; y < SIDE; y++)
        begin
            for (int x = 0; x < SIDE; x++)
            begin
                pix = tile[y][x*PW +: PW];
                white[y][x] = (pix == tbfm_pkg::WHITE_PIX);
                case (mode)
                    tbfm_pkg::MODE_TL: seed = (y == 0) || (x == 0);
                    tbfm_pkg::MODE_TR: seed = (y == 0) || (x == SIDE - 1);
                    default: seed = (y == 0) || (y == SIDE - 1) ||
                                    (x == 0) || (x == SIDE - 1);
                endcase
                mark[y][x] = white[y][x] && seed;
            end
        end
        grown = 1'b1;
        while (grown)
        begin
            grown = 1'b0;
            for (int y = 0; y < SIDE; y++)
            begin
                for (int x = 0; x < SIDE; x++)
                begin
                    if (white[y][x] && !mark[y][x] &&
                        ((x > 0 && mark[y][x-1]) || (x < SIDE - 1 && mark[y][x+1]) ||
                         (y > 0 && mark[y-1][x]) || (y < SIDE - 1 && mark[y+1][x])))
                    begin
                        mark[y][x] = 1'b1;
                        grown = 1'b1;
                    end
                end
            end
        end
        for (int y = 0; y < SIDE; y++)
        begin
            for (int x = 0; x < SIDE; x++)
            begin
                pix = tile[y][x*PW +: PW];
                if (mark[y][x])
                    pix = tbfm_pkg::BLACK_PIX;
                else if (pix == tbfm_pkg::BLACK_PIX)
                    pix = tbfm_pkg::RAISE_PIX;
                masked[y][x*PW +: PW] = pix;
            end
        end
        return masked;
    endfunction

    function automatic tile_t rows8(tbfm_pkg::row_t r0, tbfm_pkg::row_t r1,
                                    tbfm_pkg::row_t r2, tbfm_pkg::row_t r3,
                                    tbfm_pkg::row_t r4, tbfm_pkg::row_t r5,
                                    tbfm_pkg::row_t r6, tbfm_pkg::row_t r7);
        tile_t t;
        t[0] = r0; t[1] = r1; t[2] = r2; t[3] = r3;
        t[4] = r4; t[5] = r5; t[6] = r6; t[7] = r7;
        return t;
    endfunction

    function automatic tile_t flat(tbfm_pkg::row_t r);
        return rows8(r, r, r, r, r, r, r, r);
    endfunction

    function automatic tile_t framed(tbfm_pkg::row_t edge_r, tbfm_pkg::row_t mid_r);
        return rows8(edge_r, mid_r, mid_r, mid_r, mid_r, mid_r, mid_r, edge_r);
    endfunction

    function automatic tile_t random_tile();
        tile_t t;
        int    density;
        density = $urandom_range(15, 85);
        for (int y = 0; y < SIDE; y++)
        begin
            if ($urandom_range(9) == 0)
                t[y] = $urandom;
            else
                for (int x = 0; x < SIDE; x++)
                    t[y][x*PW +: PW] = ($urandom_range(99) < density) ?
                                       tbfm_pkg::WHITE_PIX :
                                       tbfm_pkg::pix_t'($urandom_range(0, 15));
        end
        return t;
    endfunction

    task automatic add_row(input tbfm_pkg::cmd_t c, input tile_t t, input logic typed,
                           input tile_t want);
        dir_row_t r;
        r.cmd   = c;
        r.tile  = t;
        r.typed = typed;
        r.want  = want;
        dir_tab.push_back(r);
    endtask

    task automatic send_tile(input tbfm_pkg::cmd_t c, input tile_t t, input tile_t want);
        while ($urandom_range(99) < req_idle_pct)
        begin
            tile_req.valid <= 1'b0;
            @(posedge clk);
        end
        tile_req.valid   <= 1'b1;
        tile_req.cmd     <= c;
        tile_req.row_in0 <= t[0];
        tile_req.row_in1 <= t[1];
        tile_req.row_in2 <= t[2];
        tile_req.row_in3 <= t[3];
        tile_req.row_in4 <= t[4];
        tile_req.row_in5 <= t[5];
        tile_req.row_in6 <= t[6];
        tile_req.row_in7 <= t[7];
        do
            @(posedge clk);
        while (!tile_req.ready);
        masked_q.push_back(want);
    endtask

    initial
    begin
        hold_off <= 1'b0;
        do
            @(posedge clk);
        while (!pressure_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        tile_rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tile_rsp.ready <= !hold_off && ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tile_rsp.valid && tile_rsp.ready)
        begin
            tile_t got;
            tile_t want;
            got = rows8(tile_rsp.row_out0, tile_rsp.row_out1, tile_rsp.row_out2,
                        tile_rsp.row_out3, tile_rsp.row_out4, tile_rsp.row_out5,
                        tile_rsp.row_out6, tile_rsp.row_out7);
            if (masked_q.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          results_seen));
            else
            begin
                want = masked_q.pop_front();
                for (int y = 0; y < SIDE; y++)
                    if (got[y] !== want[y])
                        report_mismatch($sformatf("result %0d row_out%0d: got %h, want %h",
                                                  results_seen, y, got[y], want[y]));
            end
            results_seen++;
        end
    end

    initial
    begin
        tile_t          t;
        tbfm_pkg::cmd_t c;
        tile_t          serpent;
        req_idle_pct = 7;
        pressure_go  = 1'b0;
        tile_req.valid   <= 1'b0;
        tile_req.cmd     <= tbfm_pkg::MODE_ALL;
        tile_req.row_in0 <= '0;
        tile_req.row_in1 <= '0;
        tile_req.row_in2 <= '0;
        tile_req.row_in3 <= '0;
        tile_req.row_in4 <= '0;
        tile_req.row_in5 <= '0;
        tile_req.row_in6 <= '0;
        tile_req.row_in7 <= '0;

        serpent = rows8(32'h0FFFFFFF, 32'h0F000000, 32'h0FFFFFFF, 32'h0000000F,
                        32'h0FFFFFFF, 32'h0F000000, 32'h0FFFFFFF, 32'h00000000);

        add_row(tbfm_pkg::MODE_ALL, flat(32'h00000000), 1'b1, flat(32'h11111111));
        add_row(tbfm_pkg::MODE_ALL, flat(32'hFFFFFFFF), 1'b1, flat(32'h00000000));
        add_row(tbfm_pkg::MODE_TL,  flat(32'hFFFFFFFF), 1'b1, flat(32'h00000000));
        add_row(tbfm_pkg::MODE_TR,  flat(32'hFFFFFFFF), 1'b1, flat(32'h00000000));
        add_row(MODE_SPARE,         flat(32'hFFFFFFFF), 1'b1, flat(32'h00000000));
        add_row(tbfm_pkg::MODE_ALL, flat(32'h55555555), 1'b1, flat(32'h55555555));
        add_row(tbfm_pkg::MODE_TL,  flat(32'hEEEEEEEE), 1'b1, flat(32'hEEEEEEEE));
        add_row(tbfm_pkg::MODE_ALL, framed(32'h00000000, 32'h0FFFFFF0), 1'b1,
                framed(32'h11111111, 32'h1FFFFFF1));
        add_row(tbfm_pkg::MODE_TL,
                rows8(32'h22222222, 32'h22222222, 32'h22222222, 32'h22222222,
                      32'h22222222, 32'h22222222, 32'h22222222, 32'h0FFFFFF0), 1'b1,
                rows8(32'h22222222, 32'h22222222, 32'h22222222, 32'h22222222,
                      32'h22222222, 32'h22222222, 32'h22222222, 32'h1FFFFFF1));
        add_row(tbfm_pkg::MODE_ALL,
                rows8(32'h22222222, 32'h22222222, 32'h22222222, 32'h22222222,
                      32'h22222222, 32'h22222222, 32'h22222222, 32'h0FFFFFF0), 1'b1,
                rows8(32'h22222222, 32'h22222222, 32'h22222222, 32'h22222222,
                      32'h22222222, 32'h22222222, 32'h22222222, 32'h10000001));
        add_row(tbfm_pkg::MODE_TL, framed(32'h33333333, 32'hF3333333), 1'b1,
                framed(32'h33333333, 32'hF3333333));
        add_row(tbfm_pkg::MODE_TR, framed(32'h33333333, 32'hF3333333), 1'b1,
                framed(32'h33333333, 32'h03333333));
        add_row(tbfm_pkg::MODE_TR, framed(32'h33333333, 32'h3333333F), 1'b1,
                framed(32'h33333333, 32'h3333333F));
        add_row(tbfm_pkg::MODE_TL, framed(32'h33333333, 32'h3333333F), 1'b1,
                framed(32'h33333333, 32'h33333330));
        add_row(tbfm_pkg::MODE_TR,  serpent, 1'b0, '0);
        add_row(tbfm_pkg::MODE_TL,  serpent, 1'b0, '0);
        add_row(tbfm_pkg::MODE_ALL, serpent, 1'b0, '0);
        add_row(tbfm_pkg::MODE_ALL,
                rows8(32'hF0F0F0F0, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h0F0F0F0F,
                      32'hF0F0F0F0, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h0F0F0F0F),
                1'b0, '0);
        add_row(tbfm_pkg::MODE_TR,
                rows8(32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210,
                      32'hA5A5A5A5, 32'h5A5A5A5A, 32'hC3C3C3C3, 32'h3C3C3C3C),
                1'b0, '0);
        add_row(tbfm_pkg::MODE_ALL,
                rows8(32'h00000000, 32'h000F0000, 32'h000F0000, 32'h0FFFFFF0,
                      32'h000F0000, 32'h000F0000, 32'h000F0000, 32'h00000000),
                1'b0, '0);

        @(posedge rst_n);
        @(posedge clk);

        foreach (dir_tab[i])
            send_tile(dir_tab[i].cmd, dir_tab[i].tile,
                      dir_tab[i].typed ? dir_tab[i].want
                                       : flood_mask(dir_tab[i].cmd, dir_tab[i].tile));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                req_idle_pct = 50;
                rsp_idle_pct = 7;
            end
            else if (n == 2 * N_RANDOM / 3)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
                pressure_go  = 1'b1;
            end
            c = tbfm_pkg::cmd_t'($urandom_range(0, 3));
            t = random_tile();
            send_tile(c, t, flood_mask(c, t));
        end
        tile_req.valid <= 1'b0;

        while (masked_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
